### rtl/necd_pkg.sv
// shared types, constants and the interval match function of the nec ir frame decoder
// no dependencies; imported by every module of the block

package necd_pkg;

  localparam int unsigned DataBitsDef  = 32;
  localparam int unsigned CfgW         = 20;
  localparam int unsigned IntervalW    = 24;
  localparam int unsigned WordW        = 16;
  localparam int unsigned ExpW         = 25;

  localparam logic [CfgW-1:0] UnitNsRst = 20'd562500;
  localparam logic [CfgW-1:0] TolNsRst  = 20'd90000;

  // configuration register indexes
  localparam logic [1:0] RegUnitNs    = 2'd0;
  localparam logic [1:0] RegTolNs     = 2'd1;
  localparam logic [1:0] RegInvLevel  = 2'd2;

  // which unit multiples the current interval lies near
  typedef struct packed {
    logic u1;
    logic u3;
    logic u4;
    logic u8;
    logic u16;
  } near_t;

  typedef struct packed {
    logic             frame_error;
    logic             repeat_res;
    logic [WordW-1:0] command;
    logic [WordW-1:0] address;
  } result_t;

  function automatic logic near_units(input logic [IntervalW-1:0] interval,
                                      input logic [ExpW-1:0]      expect_ns,
                                      input logic [CfgW-1:0]      tol);
    logic [ExpW-1:0] ext;
    logic [ExpW-1:0] diff;
    ext  = ExpW'(interval);
    diff = (ext >= expect_ns) ? (ext - expect_ns) : (expect_ns - ext);
    return diff <= ExpW'(tol);
  endfunction

endpackage

### rtl/necd_match.sv
// interval matcher: compares one edge interval against 1, 3, 4, 8 and 16 units
// depends on necd_pkg

module necd_match import necd_pkg::*; (
  input  logic [IntervalW-1:0] interval_i,
  input  logic [CfgW-1:0]      unit_ns_i,
  input  logic [CfgW-1:0]      tol_ns_i,
  output near_t                near_o
);

  logic [ExpW-1:0] unit1;
  logic [ExpW-1:0] unit3;
  logic [ExpW-1:0] unit4;
  logic [ExpW-1:0] unit8;
  logic [ExpW-1:0] unit16;

  // multiples are shifts, apart from 3 units which takes one add
  assign unit1  = ExpW'(unit_ns_i);
  assign unit4  = unit1 << 2;
  assign unit8  = unit1 << 3;
  assign unit16 = unit1 << 4;
  assign unit3  = (unit1 << 1) + unit1;

  assign near_o.u1  = near_units(interval_i, unit1,  tol_ns_i);
  assign near_o.u3  = near_units(interval_i, unit3,  tol_ns_i);
  assign near_o.u4  = near_units(interval_i, unit4,  tol_ns_i);
  assign near_o.u8  = near_units(interval_i, unit8,  tol_ns_i);
  assign near_o.u16 = near_units(interval_i, unit16, tol_ns_i);

endmodule

### rtl/necd_fsm.sv
// frame state machine with bit collection and the result register
// depends on necd_pkg; fed by necd_match through the top level

module necd_fsm import necd_pkg::*; #(
  parameter int unsigned DATA_BITS = DataBitsDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    rise_i,
  input  near_t   near_i,
  output logic    in_take_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  localparam int unsigned CntW = $clog2(DATA_BITS + 1);

  typedef enum logic [2:0] {
    PhIdle,
    PhLeadBurst,
    PhLeadSpace,
    PhBitBurst,
    PhBitSpace,
    PhRepBurst
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [CntW-1:0]  bit_count_q, bit_count_d;
  logic [WordW-1:0] addr_q, addr_d;
  logic [WordW-1:0] cmd_q, cmd_d;
  logic             out_valid_q;
  result_t          out_q;

  logic             emit;
  logic             emit_rep;
  logic             emit_err;
  logic             ok;
  logic [5:0]       cnt_ext;
  logic [CntW:0]    cnt_inc;
  logic             one;

  // a result slot is free when empty or being drained this cycle
  assign in_take_o   = in_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign cnt_ext = 6'(bit_count_q);
  assign cnt_inc = (CntW+1)'(bit_count_q) + 1'b1;
  assign one     = near_i.u3;

  always_comb begin
    phase_d     = phase_q;
    bit_count_d = bit_count_q;
    addr_d      = addr_q;
    cmd_d       = cmd_q;
    emit        = 1'b0;
    emit_rep    = 1'b0;
    emit_err    = 1'b0;
    ok          = 1'b1;
    case (phase_q)
      PhIdle: begin
        if (rise_i) phase_d = PhLeadBurst;
      end
      PhLeadBurst: begin
        if (!rise_i && near_i.u16) phase_d = PhLeadSpace;
        else ok = 1'b0;
      end
      PhLeadSpace: begin
        if (rise_i && near_i.u8) begin
          addr_d      = '0;
          cmd_d       = '0;
          bit_count_d = '0;
          phase_d     = PhBitBurst;
        end else if (rise_i && near_i.u4) begin
          phase_d = PhRepBurst;
        end else begin
          ok = 1'b0;
        end
      end
      PhBitBurst: begin
        if (!rise_i && near_i.u1) phase_d = PhBitSpace;
        else ok = 1'b0;
      end
      PhBitSpace: begin
        if (rise_i && (one || near_i.u1)) begin
          if (one) begin
            if (cnt_ext < 6'd16) addr_d[cnt_ext[3:0]] = 1'b1;
            else if (cnt_ext < 6'd32) cmd_d[cnt_ext[3:0]] = 1'b1;
          end
          if (cnt_inc >= (CntW+1)'(DATA_BITS)) begin
            bit_count_d = bit_count_q;
            emit        = 1'b1;
            phase_d     = PhIdle;
          end else begin
            bit_count_d = cnt_inc[CntW-1:0];
            phase_d     = PhBitBurst;
          end
        end else begin
          ok = 1'b0;
        end
      end
      PhRepBurst: begin
        if (!rise_i && near_i.u1) begin
          emit     = 1'b1;
          emit_rep = 1'b1;
          phase_d  = PhIdle;
        end else begin
          ok = 1'b0;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    // broken off: data phases report partial words, then resync on direction
    if (!ok) begin
      if (phase_q == PhBitBurst || phase_q == PhBitSpace) begin
        emit     = 1'b1;
        emit_err = 1'b1;
      end
      phase_d = rise_i ? PhLeadBurst : PhIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      bit_count_q <= '0;
      addr_q      <= '0;
      cmd_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (in_take_o) begin
      phase_q     <= phase_d;
      bit_count_q <= bit_count_d;
      addr_q      <= addr_d;
      cmd_q       <= cmd_d;
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take_o && emit) begin
      out_q.address     <= addr_d;
      out_q.command     <= cmd_d;
      out_q.repeat_res  <= emit_rep;
      out_q.frame_error <= emit_err;
    end
  end

endmodule

### rtl/nec_ir_frame_decoder.sv
// nec ir frame decoder top level: config registers, edge input register, matcher and fsm
// depends on necd_pkg, necd_match, necd_fsm
//
//  channel  | direction | beat contents
//  s_axis   | in        | one line edge: interval and direction
//  m_axis   | out       | decoded address/command with repeat and error flags
//  cfg      | in        | write of unit_ns, tolerance_ns or invert_level
//
// one beat per cycle in while s_axis_tready is high; an accepted edge sits in the input
// register, and the matcher and frame fsm load the result register from it when the fsm
// takes it, so m_axis_tvalid rises behind both registers after a frame's last edge
// the fsm holds while a result waits unread; the input register still takes one more
// beat, then s_axis_tready drops until the result drains
// reset clears control state and config to its defaults

module nec_ir_frame_decoder import necd_pkg::*; #(
  parameter int unsigned DATA_BITS = DataBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IntervalW-1:0] s_axis_tdata,   // [23:0] interval_ns
  input  logic                 s_axis_tuser,   // [0] rising
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [2*WordW-1:0]   m_axis_tdata,   // [15:0] address, [31:16] command
  output logic [1:0]           m_axis_tuser,   // [0] repeat_res, [1] frame_error
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_data_i
);

  logic [CfgW-1:0]      unit_ns_q;
  logic [CfgW-1:0]      tol_ns_q;
  logic                 inv_q;

  logic                 in_valid_q;
  logic                 in_rising_q;
  logic [IntervalW-1:0] in_interval_q;

  logic                 in_take;
  near_t                near;
  result_t              res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ns_q <= UnitNsRst;
      tol_ns_q  <= TolNsRst;
      inv_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegUnitNs:   unit_ns_q <= cfg_data_i;
        RegTolNs:    tol_ns_q  <= cfg_data_i;
        RegInvLevel: inv_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !in_valid_q || in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_rising_q   <= s_axis_tuser;
      in_interval_q <= s_axis_tdata;
    end
  end

  necd_match u_match (
    .interval_i (in_interval_q),
    .unit_ns_i  (unit_ns_q),
    .tol_ns_i   (tol_ns_q),
    .near_o     (near)
  );

  necd_fsm #(
    .DATA_BITS (DATA_BITS)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .rise_i      (in_rising_q ^ inv_q),
    .near_i      (near),
    .in_take_o   (in_take),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {res.command, res.address};
  assign m_axis_tuser = {res.frame_error, res.repeat_res};

endmodule
